// ===== sv/bled_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bled_pkg
// Shared types and constants of the advertising report device detector.
// ---------------------------------------------------------------------------
package bled_pkg;

   // fixed widths of the report fields
   localparam int ADDR_W   = 48;
   localparam int PREFIX_W = 24;
   localparam int LEN_W    = 5;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_PREFIX_ONE   = 2'd0;
   localparam logic [1:0] CSR_PREFIX_TWO   = 2'd1;
   localparam logic [1:0] CSR_PREFIX_THREE = 2'd2;

   // register reset values
   localparam logic [PREFIX_W-1:0] PREFIX_ONE_RST   = 24'h0CFA22;
   localparam logic [PREFIX_W-1:0] PREFIX_TWO_RST   = 24'h80E126;
   localparam logic [PREFIX_W-1:0] PREFIX_THREE_RST = 24'h80E127;

   // structure type codes for a local name
   localparam logic [7:0] AD_NAME_SHORT    = 8'h08;
   localparam logic [7:0] AD_NAME_COMPLETE = 8'h09;

   // seven byte name pattern, entry 0 first on the air
   localparam logic [LEN_W-1:0] PAT_LEN = 5'd7;
   localparam logic [6:0][7:0] PAT_BYTES =
      {8'h72, 8'h65, 8'h70, 8'h70, 8'h69, 8'h6C, 8'h46};

   // parser phase within the length/type/data walk
   typedef enum logic [1:0] {
      PH_LEN,
      PH_TYPE,
      PH_DATA,
      PH_STOP
   } parse_phase_type;

   // verdict of one finished report, as queued for the back end
   typedef struct packed {
      logic                 is_match;
      logic                 by_prefix;
      logic                 by_name;
      logic [ADDR_W-1:0]    address;
      logic signed [7:0]    strength;
      logic [LEN_W-1:0]     count;
   } verdict_type;

endpackage : bled_pkg
`default_nettype wire

// ===== sv/bled_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bled_fifo
// Two-entry queue of finished report verdicts between parser and emitter.
// ---------------------------------------------------------------------------
module bled_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output logic [WIDTH-1:0]      head
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store an incoming verdict
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : bled_fifo
`default_nettype wire

// ===== sv/bled_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bled_front
// Walks advertising structures one byte a beat, captures a matching name
// and forms the verdict of each report at its last beat.
// ---------------------------------------------------------------------------
module bled_front
   import bled_pkg::*;
#(
   parameter int NAME_MAX = 23
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [PREFIX_W-1:0]   csr_wdata,
   input  wire logic                  take,
   input  wire logic [ADDR_W-1:0]     dev_address,
   input  wire logic signed [7:0]     signal_strength,
   input  wire logic [7:0]            payload_byte,
   input  wire logic                  byte_present,
   input  wire logic                  report_end,
   output logic                       job_push,
   output verdict_type                job_verdict,
   output logic [NAME_MAX-1:0][7:0]   job_name
);

   localparam int IDX_W = $clog2(NAME_MAX);

   logic [PREFIX_W-1:0] prefix_one_ff, prefix_two_ff, prefix_three_ff;

   parse_phase_type   phase_ff, phase_in;
   logic [7:0]        left_ff, left_in, left_b;
   logic [7:0]        kind_ff, kind_in, kind_b;
   logic              pat_ok_ff, pat_ok_in, pat_ok_b;
   logic [LEN_W-1:0]  cand_len_ff, cand_len_in, cand_len_b;
   logic [NAME_MAX-1:0][7:0] cand_buf_ff, cand_buf_in;
   logic [NAME_MAX-1:0][7:0] kept_ff, kept_in;
   logic [LEN_W-1:0]  kept_len_ff, kept_len_in, kept_len_b;
   logic              found_ff, found_in, found_b;

   logic              byte_take;
   logic              pat_hit, capture;
   logic [PREFIX_W-1:0] top_octets;
   logic              by_prefix, match;
   logic [NAME_MAX-1:0][7:0] default_name;

   assign byte_take = take && byte_present;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_one_ff   <= PREFIX_ONE_RST;
         prefix_two_ff   <= PREFIX_TWO_RST;
         prefix_three_ff <= PREFIX_THREE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PREFIX_ONE:   prefix_one_ff   <= csr_wdata;
            CSR_PREFIX_TWO:   prefix_two_ff   <= csr_wdata;
            CSR_PREFIX_THREE: prefix_three_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next parser phase
   always_comb begin
      phase_in = phase_ff;
      if (take && report_end) begin
         phase_in = PH_LEN;
      end else if (byte_take) begin
         unique case (phase_ff)
            PH_LEN:  phase_in = (payload_byte == 8'd0) ? PH_STOP : PH_TYPE;
            PH_TYPE: phase_in = (left_ff == 8'd0) ? PH_LEN : PH_DATA;
            PH_DATA: phase_in = (left_ff == 8'd1) ? PH_LEN : PH_DATA;
            PH_STOP: phase_in = PH_STOP;
            default: phase_in = PH_LEN;
         endcase
      end
   end

   // pattern check of the current data byte
   always_comb begin
      pat_hit = 1'b1;
      if (cand_len_ff < PAT_LEN) begin
         pat_hit = (payload_byte == PAT_BYTES[cand_len_ff[2:0]]);
      end
   end

   // parse state after this beat's byte
   always_comb begin
      left_b      = left_ff;
      kind_b      = kind_ff;
      pat_ok_b    = pat_ok_ff;
      cand_len_b  = cand_len_ff;
      cand_buf_in = cand_buf_ff;
      capture     = 1'b0;
      if (byte_take) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (payload_byte != 8'd0) begin
                  left_b = payload_byte - 8'd1;
               end
            end
            PH_TYPE: begin
               kind_b     = payload_byte;
               pat_ok_b   = 1'b1;
               cand_len_b = '0;
            end
            PH_DATA: begin
               pat_ok_b = pat_ok_ff && pat_hit;
               if (cand_len_ff < LEN_W'(NAME_MAX)) begin
                  cand_buf_in[cand_len_ff[IDX_W-1:0]] = payload_byte;
                  cand_len_b = cand_len_ff + 5'd1;
               end
               left_b  = left_ff - 8'd1;
               capture = (left_ff == 8'd1) && pat_ok_b && (cand_len_b >= PAT_LEN) &&
                         ((kind_ff == AD_NAME_SHORT) || (kind_ff == AD_NAME_COMPLETE));
            end
            PH_STOP: ;
            default: ;
         endcase
      end
   end

   // keep a finished name structure
   always_comb begin
      kept_in    = capture ? cand_buf_in : kept_ff;
      kept_len_b = capture ? cand_len_b : kept_len_ff;
      found_b    = capture || found_ff;
   end

   // clear parse state at report end
   always_comb begin
      left_in     = left_b;
      kind_in     = kind_b;
      pat_ok_in   = pat_ok_b;
      cand_len_in = cand_len_b;
      kept_len_in = kept_len_b;
      found_in    = found_b;
      if (take && report_end) begin
         left_in     = '0;
         kind_in     = '0;
         pat_ok_in   = 1'b0;
         cand_len_in = '0;
         kept_len_in = '0;
         found_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEN;
         left_ff     <= '0;
         kind_ff     <= '0;
         pat_ok_ff   <= 1'b0;
         cand_len_ff <= '0;
         kept_len_ff <= '0;
         found_ff    <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         kind_ff     <= kind_in;
         pat_ok_ff   <= pat_ok_in;
         cand_len_ff <= cand_len_in;
         kept_len_ff <= kept_len_in;
         found_ff    <= found_in;
      end
   end

   // name buffers hold no reset
   always_ff @(posedge clock) begin
      cand_buf_ff <= cand_buf_in;
      kept_ff     <= kept_in;
   end

   // verdict at report end
   always_comb begin
      default_name = '0;
      for (int i = 0; i < 7; i++) begin
         default_name[i] = PAT_BYTES[i];
      end
   end

   assign top_octets = dev_address[ADDR_W-1 -: PREFIX_W];
   assign by_prefix  = (top_octets == prefix_one_ff) || (top_octets == prefix_two_ff) ||
                       (top_octets == prefix_three_ff);
   assign match      = by_prefix || found_b;
   assign job_push   = take && report_end;

   always_comb begin
      job_verdict = '0;
      job_name    = '0;
      if (match) begin
         job_verdict.is_match  = 1'b1;
         job_verdict.by_prefix = by_prefix;
         job_verdict.by_name   = found_b;
         job_verdict.address   = dev_address;
         job_verdict.strength  = signal_strength;
         job_verdict.count     = found_b ? kept_len_b : PAT_LEN;
         job_name              = found_b ? kept_in : default_name;
      end else begin
         job_verdict.count = 5'd1;
      end
   end

endmodule : bled_front
`default_nettype wire

// ===== sv/bled_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bled_back
// Emits one result beat per name character of the oldest queued verdict.
// ---------------------------------------------------------------------------
module bled_back
   import bled_pkg::*;
#(
   parameter int NAME_MAX = 23
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_empty,
   input  wire verdict_type           head_verdict,
   input  wire logic [NAME_MAX-1:0][7:0] head_name,
   output logic                       head_pop,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic                       rsp_is_match,
   output logic                       rsp_matched_by_prefix,
   output logic                       rsp_matched_by_name,
   output logic [ADDR_W-1:0]          rsp_out_address,
   output logic signed [7:0]          rsp_out_strength,
   output logic [7:0]                 rsp_name_char,
   output logic [LEN_W-1:0]           rsp_name_length,
   output logic                       rsp_run_last
);

   localparam int IDX_W = $clog2(NAME_MAX);

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             fire, last;

   assign rsp_empty = head_empty;
   assign last      = (idx_ff == head_verdict.count - 5'd1);
   assign fire      = rsp_pop && !head_empty;
   assign head_pop  = fire && last;

   // advance the character index
   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = last ? '0 : idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // result fields from the queue head
   assign rsp_is_match          = head_verdict.is_match;
   assign rsp_matched_by_prefix = head_verdict.by_prefix;
   assign rsp_matched_by_name   = head_verdict.by_name;
   assign rsp_out_address       = head_verdict.address;
   assign rsp_out_strength      = head_verdict.strength;
   assign rsp_name_char         = head_name[idx_ff[IDX_W-1:0]];
   assign rsp_name_length       = head_verdict.is_match ? head_verdict.count : '0;
   assign rsp_run_last          = last;

`ifndef SYNTHESIS
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> (idx_ff < head_verdict.count))
      else $error("character index beyond run length");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> (head_verdict.count != 5'd0))
      else $error("queued run has no result");

   a_nomatch_single: assert property (@(posedge clock) disable iff (reset)
      (!head_empty && !head_verdict.is_match) |-> (head_verdict.count == 5'd1))
      else $error("unmatched report with more than one result");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (fire && !last) |=> (!head_empty && (idx_ff == $past(idx_ff) + 5'd1)))
      else $error("run did not advance by one character");
`endif

endmodule : bled_back
`default_nettype wire

// ===== sv/ble_adv_device_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ble_adv_device_detector
// Parses advertising reports byte by byte and reports devices identified by
// address prefix or by local name, one result beat per name character.
// ---------------------------------------------------------------------------
//  channel   handshake          beat
//  req_      push / full        one payload byte, with address and RSSI
//  rsp_      empty / pop        one name character of a verdict
//  csr_      we                 one prefix register write
//
//  A payload byte is taken every cycle while full is low. Full rises only
//  when two finished verdicts wait in the queue between parser and
//  emitter. A report gives 1 to NAME_MAX result beats, one per cycle while
//  pop is high, paced by the emitter's character counter.
//  Reset is synchronous; the name buffers are not cleared.
// ---------------------------------------------------------------------------
module ble_adv_device_detector
   import bled_pkg::*;
#(
   parameter int NAME_MAX = 23
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [47:0]         req_dev_address,
   input  wire logic signed [7:0]   req_signal_strength,
   input  wire logic [7:0]          req_payload_byte,
   input  wire logic                req_byte_present,
   input  wire logic                req_report_end,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic                     rsp_is_match,
   output logic                     rsp_matched_by_prefix,
   output logic                     rsp_matched_by_name,
   output logic [47:0]              rsp_out_address,
   output logic signed [7:0]        rsp_out_strength,
   output logic [7:0]               rsp_name_char,
   output logic [4:0]               rsp_name_length,
   output logic                     rsp_run_last,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [23:0]         csr_wdata
);

   localparam int NAME_W = NAME_MAX * 8;
   localparam int Q_W    = $bits(verdict_type) + NAME_W;

   logic                      take;
   logic                      job_push;
   verdict_type               job_verdict;
   logic [NAME_MAX-1:0][7:0]  job_name;
   logic                      q_full, q_empty, q_pop;
   logic [Q_W-1:0]            q_head;
   verdict_type               head_verdict;
   logic [NAME_MAX-1:0][7:0]  head_name;

   assign req_full = q_full;
   assign take     = req_push && !q_full;

   // parser
   bled_front #(
      .NAME_MAX (NAME_MAX)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .take            (take),
      .dev_address     (req_dev_address),
      .signal_strength (req_signal_strength),
      .payload_byte    (req_payload_byte),
      .byte_present    (req_byte_present),
      .report_end      (req_report_end),
      .job_push        (job_push),
      .job_verdict     (job_verdict),
      .job_name        (job_name)
   );

   // verdict queue
   bled_fifo #(
      .WIDTH (Q_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_verdict, job_name}),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   assign head_verdict = q_head[Q_W-1 -: $bits(verdict_type)];
   assign head_name    = q_head[NAME_W-1:0];

   // emitter
   bled_back #(
      .NAME_MAX (NAME_MAX)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_empty            (q_empty),
      .head_verdict          (head_verdict),
      .head_name             (head_name),
      .head_pop              (q_pop),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_is_match          (rsp_is_match),
      .rsp_matched_by_prefix (rsp_matched_by_prefix),
      .rsp_matched_by_name   (rsp_matched_by_name),
      .rsp_out_address       (rsp_out_address),
      .rsp_out_strength      (rsp_out_strength),
      .rsp_name_char         (rsp_name_char),
      .rsp_name_length       (rsp_name_length),
      .rsp_run_last          (rsp_run_last)
   );

endmodule : ble_adv_device_detector
`default_nettype wire
